// File: rtl/core/ncs_pkg.sv
// Package for the neighborhood contrast stretch block.
// Holds payload structs, configuration codes, pipeline structs and the size clamp.
// No dependencies; imported by every module under rtl/core.
package ncs_pkg;

    // Default build limits
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 4096;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 13;
    localparam int STEP_REG_W   = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP   = 2'd2;

    localparam int WIDTH_RST  = 640;
    localparam int HEIGHT_RST = 480;
    localparam logic [STEP_REG_W-1:0] STEP_RST = 8'd1;

    // Smallest frame dimension the window logic supports
    localparam int MIN_SIZE = 3;

    // Item opcodes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [7:0] CHAN_MAX = 8'd255;

    // Pixel packing: blue in [7:0], green in [15:8], red in [23:16]
    typedef logic [23:0] pixel_t;

    typedef struct packed {
        logic       opcode;
        logic [7:0] in_blue;
        logic [7:0] in_green;
        logic [7:0] in_red;
    } src_item_t;

    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic       frame_last;
    } dst_item_t;

    // Position flags of the output pixel an item produces
    typedef struct packed {
        logic emit;
        logic border;
        logic last;
    } pos_info_t;

    // Window extremes handed from the window stage to the stretch stage
    typedef struct packed {
        logic   border;
        logic   last;
        pixel_t center;
        pixel_t lo;
        pixel_t hi;
    } minmax_t;

    // Clamp a frame dimension into [MIN_SIZE, hi]
    function automatic logic [31:0] clamp_size(input logic [31:0] v, input logic [31:0] hi);
        logic [31:0] r;
        priority if (v < 32'(MIN_SIZE))
            r = 32'(MIN_SIZE);
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

endpackage

// File: rtl/core/ncs_line_store.sv
// Two-row line store: one synchronous RAM holding {upper, middle} per column.
// Registered read, one write port, write-to-read bypass on the same address.
// Depends on ncs_pkg.
module ncs_line_store #(
    parameter int DEPTH = ncs_pkg::MAX_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [47:0]              wr_data,
    output logic [47:0]              rd_data
);
    import ncs_pkg::*;

    logic [47:0] mem [DEPTH];
    logic [47:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; a write to the same entry in the same cycle is forwarded
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
                rd_data_reg <= wr_data;
            else
                rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/ncs_scan.sv
// Raster scan control: configuration registers, column/row counters and the
// first pipeline stage (pixel, column, position flags). Depends on ncs_pkg.
module ncs_scan #(
    parameter int MAX_WIDTH  = ncs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ncs_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [ncs_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [ncs_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 en,
    input  logic                                 accept,
    input  ncs_pkg::src_item_t                   src_item,
    output logic [$clog2(MAX_WIDTH)-1:0]         rd_col,
    output logic [ncs_pkg::STEP_REG_W-1:0]       step_amount,
    output logic                                 a_valid,
    output logic [$clog2(MAX_WIDTH)-1:0]         a_col,
    output ncs_pkg::pixel_t                      a_pix,
    output ncs_pkg::pos_info_t                   a_pos
);
    import ncs_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2);

    logic [WW-1:0]         w_reg, w_next;
    logic [HW-1:0]         h_reg, h_next;
    logic [STEP_REG_W-1:0] step_reg, step_next;
    logic [CW-1:0]         col_reg, col_next;
    logic [RW-1:0]         row_reg, row_next;
    logic [WW-1:0]         col_inc;
    logic [RW-1:0]         h_ext;

    logic                  a_valid_reg;
    logic [CW-1:0]         a_col_reg;
    pixel_t                a_pix_reg;
    pos_info_t             a_pos_reg;

    pixel_t                pix;
    pos_info_t             pos;

    assign col_inc = WW'(col_reg) + WW'(1);
    assign h_ext   = RW'(h_reg);

    // Pixel value; drain items and pixels past the frame enter as zero
    always_comb
    begin
        if ((src_item.opcode == OP_PIXEL) && (row_reg < h_ext))
            pix = {src_item.in_red, src_item.in_green, src_item.in_blue};
        else
            pix = '0;
    end

    // Position of the pixel that leaves the window with this transaction
    always_comb
    begin
        pos.emit   = (row_reg >= RW'(2)) || ((row_reg == RW'(1)) && (col_reg != '0));
        pos.border = (col_reg == '0) || (col_reg == CW'(1)) || (row_reg <= RW'(1))
                     || (row_reg >= h_ext);
        pos.last   = (col_reg == '0) && (row_reg == h_ext + RW'(1));
    end

    // Counter and configuration update
    always_comb
    begin
        w_next    = w_reg;
        h_next    = h_reg;
        step_next = step_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH:
                begin
                    w_next   = WW'(clamp_size(32'(cfg_data[WIDTH_REG_W-1:0]), 32'(MAX_WIDTH)));
                    col_next = '0;
                    row_next = '0;
                end
                REG_HEIGHT:
                begin
                    h_next   = HW'(clamp_size(32'(cfg_data[HEIGHT_REG_W-1:0]),
                                              32'(MAX_HEIGHT)));
                    col_next = '0;
                    row_next = '0;
                end
                REG_STEP:
                begin
                    step_next = cfg_data[STEP_REG_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
        else if (accept)
        begin
            if (pos.emit && pos.last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_inc >= w_reg)
            begin
                col_next = '0;
                if (row_reg <= RW'(MAX_HEIGHT))
                    row_next = row_reg + RW'(1);
            end
            else
            begin
                col_next = CW'(col_inc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg    <= WW'(clamp_size(32'(WIDTH_RST), 32'(MAX_WIDTH)));
            h_reg    <= HW'(clamp_size(32'(HEIGHT_RST), 32'(MAX_HEIGHT)));
            step_reg <= STEP_RST;
            col_reg  <= '0;
            row_reg  <= '0;
        end
        else
        begin
            w_reg    <= w_next;
            h_reg    <= h_next;
            step_reg <= step_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
        end
    end

    // First pipeline stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (en)
            a_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_col_reg <= col_reg;
            a_pix_reg <= pix;
            a_pos_reg <= pos;
        end
    end

    assign rd_col      = col_reg;
    assign step_amount = step_reg;
    assign a_valid     = a_valid_reg;
    assign a_col       = a_col_reg;
    assign a_pix       = a_pix_reg;
    assign a_pos       = a_pos_reg;

`ifndef SYNTHESIS
    // Column counter always stays inside the active width
    assert_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        WW'(col_reg) < w_reg)
        else $error("column counter beyond frame width");

    // Row counter never passes the last flushing row
    assert_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= h_ext + RW'(1))
        else $error("row counter beyond frame end");

    // The transaction carrying the frame's last result restarts the scan
    assert_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !cfg_we && pos.emit && pos.last) |=> (col_reg == '0) && (row_reg == '0))
        else $error("scan did not restart after frame end");
`endif

endmodule

// File: rtl/core/ncs_window.sv
// 3x3 window registers and per-channel min/max stage.
// Takes line-store read data and the new pixel; depends on ncs_pkg.
module ncs_window (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               a_valid,
    input  ncs_pkg::pixel_t    a_pix,
    input  ncs_pkg::pos_info_t a_pos,
    input  logic [47:0]        line_data,
    output logic               c_valid,
    output ncs_pkg::minmax_t   c_data
);
    import ncs_pkg::*;

    pixel_t    win_reg [9];
    logic      b_valid_reg;
    logic      b_border_reg;
    logic      b_last_reg;
    logic      c_valid_reg;
    minmax_t   c_data_reg;
    minmax_t   mm;
    logic      shift;

    assign shift = en && a_valid;

    // Shift window left; right column is {upper, middle, new pixel}
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
        end
        else if (shift)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= line_data[47:24];
            win_reg[3] <= win_reg[4];
            win_reg[4] <= win_reg[5];
            win_reg[5] <= line_data[23:0];
            win_reg[6] <= win_reg[7];
            win_reg[7] <= win_reg[8];
            win_reg[8] <= a_pix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (en)
            b_valid_reg <= a_valid && a_pos.emit;
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            b_border_reg <= a_pos.border;
            b_last_reg   <= a_pos.last;
        end
    end

    // Per-channel extremes over the nine pixels
    always_comb
    begin
        mm.border = b_border_reg;
        mm.last   = b_last_reg;
        mm.center = win_reg[4];
        mm.lo     = win_reg[0];
        mm.hi     = win_reg[0];
        for (int i = 1; i < 9; i++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (win_reg[i][c*8 +: 8] < mm.lo[c*8 +: 8])
                    mm.lo[c*8 +: 8] = win_reg[i][c*8 +: 8];
                if (win_reg[i][c*8 +: 8] > mm.hi[c*8 +: 8])
                    mm.hi[c*8 +: 8] = win_reg[i][c*8 +: 8];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (en)
            c_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en && b_valid_reg)
            c_data_reg <= mm;
    end

    assign c_valid = c_valid_reg;
    assign c_data  = c_data_reg;

endmodule

// File: rtl/core/ncs_stretch.sv
// Stretch decision and saturation per channel, plus the output register.
// Depends on ncs_pkg.
module ncs_stretch (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             c_valid,
    input  ncs_pkg::minmax_t                 c_data,
    input  logic [ncs_pkg::STEP_REG_W-1:0]   step_amount,
    output logic                             dst_valid,
    output ncs_pkg::dst_item_t               dst_data
);
    import ncs_pkg::*;

    logic      out_valid_reg;
    dst_item_t out_reg;
    pixel_t    res;

    // Move each channel away from the window's midpoint by the step
    always_comb
    begin
        logic [7:0] p;
        logic [7:0] lo;
        logic [7:0] hi;
        logic [8:0] d;
        logic [8:0] r;
        logic [8:0] sum;
        res = c_data.center;
        for (int c = 0; c < 3; c++)
        begin
            p   = c_data.center[c*8 +: 8];
            lo  = c_data.lo[c*8 +: 8];
            hi  = c_data.hi[c*8 +: 8];
            d   = {p - lo, 1'b0};
            r   = {1'b0, hi - lo};
            sum = {1'b0, p} + {1'b0, step_amount};
            if (!c_data.border && (lo != hi))
            begin
                priority if (d < r)
                    res[c*8 +: 8] = (p > step_amount) ? (p - step_amount) : 8'd0;
                else if (d > r)
                    res[c*8 +: 8] = (sum < {1'b0, CHAN_MAX}) ? sum[7:0] : CHAN_MAX;
                else
                    res[c*8 +: 8] = p;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= c_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en && c_valid)
        begin
            out_reg.out_blue   <= res[7:0];
            out_reg.out_green  <= res[15:8];
            out_reg.out_red    <= res[23:16];
            out_reg.frame_last <= c_data.last;
        end
    end

    assign dst_valid = out_valid_reg;
    assign dst_data  = out_reg;

endmodule

// File: rtl/core/neighborhood_contrast_stretch.sv
// Top level of the 3x3 local contrast stretch; instantiates ncs_scan,
// ncs_line_store, ncs_window and ncs_stretch. Depends on ncs_pkg.
//
// Accepts one transaction per clock and gives one result per clock when the
// output side does not stall. A result passes, after the input transaction
// that causes it, through the scan register with the line-store read, the
// window, the min/max register and the output register; in stream terms the
// result for pixel k comes with input transaction k + width + 1, so the frame
// tail is flushed with drain items.
// The throughput is set by the single line-store RAM, which does one read and
// one write-back per transaction. The RAM needs no clearing after reset.
// Configuration writes restart the frame when they change width or height
// and must only be issued while the pipeline is empty.
module neighborhood_contrast_stretch #(
    parameter int MAX_WIDTH  = ncs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ncs_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ncs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ncs_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            src_valid,
    output logic                            src_stall,
    input  ncs_pkg::src_item_t              src_data,
    output logic                            dst_valid,
    input  logic                            dst_stall,
    output ncs_pkg::dst_item_t              dst_data
);
    import ncs_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic                  en;
    logic                  accept;
    logic [CW-1:0]         rd_col;
    logic [STEP_REG_W-1:0] step_amount;
    logic                  a_valid;
    logic [CW-1:0]         a_col;
    pixel_t                a_pix;
    pos_info_t             a_pos;
    logic [47:0]           line_data;
    logic                  c_valid;
    minmax_t               c_data;

    // Whole pipeline advances unless a finished result is held
    assign en        = !(dst_valid && dst_stall);
    assign src_stall = !en;
    assign accept    = src_valid && en;

    ncs_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .en          (en),
        .accept      (accept),
        .src_item    (src_data),
        .rd_col      (rd_col),
        .step_amount (step_amount),
        .a_valid     (a_valid),
        .a_col       (a_col),
        .a_pix       (a_pix),
        .a_pos       (a_pos)
    );

    // Write back {old middle -> upper, new pixel -> middle}
    ncs_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (rd_col),
        .wr_en   (en && a_valid),
        .wr_addr (a_col),
        .wr_data ({line_data[23:0], a_pix}),
        .rd_data (line_data)
    );

    ncs_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .a_valid   (a_valid),
        .a_pix     (a_pix),
        .a_pos     (a_pos),
        .line_data (line_data),
        .c_valid   (c_valid),
        .c_data    (c_data)
    );

    ncs_stretch u_stretch (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .c_valid     (c_valid),
        .c_data      (c_data),
        .step_amount (step_amount),
        .dst_valid   (dst_valid),
        .dst_data    (dst_data)
    );

endmodule

// File: verif/tb_neighborhood_contrast_stretch.sv
// Self-checking testbench for neighborhood_contrast_stretch (3x3 local contrast stretch).
// Predicts every result from its own copy of the line stores and window state.
// Depends on ncs_pkg and the RTL under rtl/core.
`timescale 1ns / 100ps

module tb_neighborhood_contrast_stretch;
    import ncs_pkg::*;

    localparam int MAX_WIDTH     = ncs_pkg::MAX_WIDTH_DEF;
    localparam int MAX_HEIGHT    = ncs_pkg::MAX_HEIGHT_DEF;
    localparam int IDLE_SLACK    = 12;     // pipeline is four stages deep
    localparam int HOLD_CYCLES   = 400;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int REPORT_MAX    = 10;

    // index with no register behind it; writes to it are dropped
    localparam logic [CFG_INDEX_W-1:0] REG_NONE = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   src_valid;
    logic                   src_stall;
    src_item_t              src_data;
    logic                   dst_valid;
    logic                   dst_stall;
    dst_item_t              dst_data;

    // idling controls, read by the sender task and the receiver process
    int src_gap_pct   = 25;
    int dst_stall_pct = 63;
    bit hold_pending  = 1'b0;

    // predicted block state
    pixel_t      upper_row  [MAX_WIDTH];
    pixel_t      middle_row [MAX_WIDTH];
    pixel_t      nbhd       [9];
    int unsigned scan_col;
    int unsigned scan_row;
    int unsigned emitted;
    int unsigned frame_w;
    int unsigned frame_h;
    logic [7:0]  stretch_step;

    dst_item_t   expected_pixels [$];
    dst_item_t   want;
    int unsigned failures     = 0;
    int unsigned items_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned frames_seen  = 0;

    neighborhood_contrast_stretch #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void restart_scan();
        scan_col = 0;
        scan_row = 0;
        emitted  = 0;
    endfunction

    // one channel of an interior pixel: push away from the window midpoint
    function automatic logic [7:0] stretched_channel(input int unsigned sh);
        logic [7:0] p;
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] v;
        logic [8:0] twice_off;
        logic [8:0] span;
        logic [8:0] sum;
        int         i;
        p  = nbhd[4][sh +: 8];
        lo = CHAN_MAX;
        hi = 8'd0;
        for (i = 0; i < 9; i++)
        begin
            v = nbhd[i][sh +: 8];
            if (v < lo) lo = v;
            if (v > hi) hi = v;
        end
        if (lo == hi)
            return p;
        twice_off = {p - lo, 1'b0};
        span      = {1'b0, hi - lo};
        sum       = {1'b0, p} + {1'b0, stretch_step};
        if (twice_off < span)
            return (p > stretch_step) ? p - stretch_step : 8'd0;
        if (twice_off > span)
            return (sum < {1'b0, CHAN_MAX}) ? sum[7:0] : CHAN_MAX;
        return p;
    endfunction

    // advance the predicted state by one accepted transaction
    task automatic predict_output(input src_item_t item);
        int unsigned col;
        int unsigned row;
        int unsigned out_row;
        int unsigned out_col;
        pixel_t      pix;
        logic        emit;
        logic        border;
        dst_item_t   res;
        col = (scan_col >= frame_w) ? 0 : scan_col;
        row = scan_row;
        // drains and pixels past the frame enter as zero
        pix = '0;
        if (item.opcode == OP_PIXEL && row < frame_h)
            pix = {item.in_red, item.in_green, item.in_blue};

        // shift the window one column and pull in the stored rows
        nbhd[0] = nbhd[1];
        nbhd[1] = nbhd[2];
        nbhd[3] = nbhd[4];
        nbhd[4] = nbhd[5];
        nbhd[6] = nbhd[7];
        nbhd[7] = nbhd[8];
        nbhd[2] = upper_row[col];
        nbhd[5] = middle_row[col];
        nbhd[8] = pix;
        upper_row[col]  = middle_row[col];
        middle_row[col] = pix;

        emit = (row >= 2) || (row == 1 && col >= 1);
        if (col >= 1)
        begin
            out_col = col - 1;
            out_row = row - 1;
        end
        else
        begin
            out_col = frame_w - 1;
            out_row = (row >= 2) ? row - 2 : 0;
        end

        col++;
        if (col >= frame_w)
        begin
            col = 0;
            if (row <= MAX_HEIGHT) row++;
        end
        scan_col = col;
        scan_row = row;

        if (emit)
        begin
            border = (out_row == 0) || (out_row >= frame_h - 1) ||
                     (out_col == 0) || (out_col >= frame_w - 1);
            if (border)
            begin
                res.out_blue  = nbhd[4][7:0];
                res.out_green = nbhd[4][15:8];
                res.out_red   = nbhd[4][23:16];
            end
            else
            begin
                res.out_blue  = stretched_channel(0);
                res.out_green = stretched_channel(8);
                res.out_red   = stretched_channel(16);
            end
            emitted++;
            res.frame_last = (emitted >= frame_w * frame_h);
            if (res.frame_last) restart_scan();
            expected_pixels.push_back(res);
        end
    endtask

    // configuration write, mirrored into the predicted registers
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (index)
            REG_WIDTH:
            begin
                frame_w = 32'(value[WIDTH_REG_W-1:0]);
                if (frame_w < MIN_SIZE) frame_w = MIN_SIZE;
                else if (frame_w > MAX_WIDTH) frame_w = MAX_WIDTH;
                restart_scan();
            end
            REG_HEIGHT:
            begin
                frame_h = 32'(value[HEIGHT_REG_W-1:0]);
                if (frame_h < MIN_SIZE) frame_h = MIN_SIZE;
                else if (frame_h > MAX_HEIGHT) frame_h = MAX_HEIGHT;
                restart_scan();
            end
            REG_STEP:
                stretch_step = value[STEP_REG_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // offer one transaction, with random gaps ahead of it
    task automatic send_item(input src_item_t item);
        while ($urandom_range(99) < src_gap_pct)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= item;
        @(posedge clk);
        while (src_stall !== 1'b0) @(posedge clk);
        predict_output(item);
        items_sent++;
    endtask

    // stop offering, let every pending result out, then let the pipe empty
    task automatic wait_for_drain();
        src_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (IDLE_SLACK) @(posedge clk);
    endtask

    function automatic logic [7:0] chan_value(input int base, input int spread);
        int v;
        if (spread >= 255)
            return 8'($urandom_range(255));
        v = base + int'($urandom_range(2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    // one frame in raster order plus its flush; a cut frame stops early
    task automatic send_frame(input bit cut);
        src_item_t   item;
        int unsigned total;
        int unsigned npix;
        int unsigned i;
        int          spread;
        int          base_b;
        int          base_g;
        int          base_r;
        total = frame_w * frame_h;
        npix  = cut ? $urandom_range(total, 1) : total;
        case ($urandom_range(4))
            0: spread = 255;
            1: spread = 40;
            2: spread = 6;
            3: spread = 1;
            default: spread = 0;    // flat areas
        endcase
        base_b = $urandom_range(255);
        base_g = $urandom_range(255);
        base_r = $urandom_range(255);
        for (i = 0; i < npix; i++)
        begin
            item.opcode   = ($urandom_range(99) < 4) ? OP_DRAIN : OP_PIXEL;
            item.in_blue  = chan_value(base_b, spread);
            item.in_green = chan_value(base_g, spread);
            item.in_red   = chan_value(base_r, spread);
            send_item(item);
        end
        if (!cut)
        begin
            // flush: pixels past the frame are dropped just like drains
            for (i = 0; i <= frame_w; i++)
            begin
                item.opcode   = $urandom_range(1) ? OP_DRAIN : OP_PIXEL;
                item.in_blue  = 8'($urandom_range(255));
                item.in_green = 8'($urandom_range(255));
                item.in_red   = 8'($urandom_range(255));
                send_item(item);
            end
        end
    endtask

    // 4x4 frame hitting flat, low and high saturation and the exact-midpoint tie
    task automatic test_directed_cases();
        logic [7:0] green_grid [16];
        src_item_t  item;
        int         i;
        green_grid = '{8'd0, 8'd0,   8'd0,   8'd0,
                       8'd0, 8'd10,  8'd250, 8'd255,
                       8'd0, 8'd127, 8'd255, 8'd255,
                       8'd255, 8'd255, 8'd255, 8'd255};
        wait_for_drain();
        write_reg(REG_WIDTH, 13'd4);
        write_reg(REG_HEIGHT, 13'd4);
        write_reg(REG_STEP, 13'd200);
        for (i = 0; i < 16; i++)
        begin
            // last pixel of the frame is a drain standing in for zero
            item.opcode   = (i == 15) ? OP_DRAIN : OP_PIXEL;
            item.in_green = green_grid[i];
            item.in_red   = (i == 9) ? 8'd100 : (i >= 12) ? 8'd200 : 8'd0;
            item.in_blue  = (i == 3) ? 8'd255 : 8'd77;
            send_item(item);
        end
        for (i = 0; i < 5; i++)
        begin
            item.opcode   = i[0] ? OP_DRAIN : OP_PIXEL;
            item.in_blue  = 8'($urandom_range(255));
            item.in_green = 8'($urandom_range(255));
            item.in_red   = 8'($urandom_range(255));
            send_item(item);
        end
    endtask

    // sizes below the minimum, bits above the register width, a tall frame
    task automatic test_frame_size_limits();
        src_item_t item;
        int        i;
        wait_for_drain();
        write_reg(REG_WIDTH, 13'd0);
        write_reg(REG_HEIGHT, 13'd0);
        write_reg(REG_STEP, 13'd255);
        send_frame(1'b0);
        wait_for_drain();
        write_reg(REG_WIDTH, 13'h1005);  // bit 12 is not part of the width
        write_reg(REG_HEIGHT, 13'd4);
        write_reg(REG_STEP, 13'd0);
        send_frame(1'b0);
        wait_for_drain();
        write_reg(REG_WIDTH, 13'd3);
        write_reg(REG_HEIGHT, 13'h1FFF);
        write_reg(REG_STEP, 13'h1F05);  // upper bits are not part of the step
        // only the top rows of the clamped tall frame
        for (i = 0; i < 60; i++)
        begin
            item.opcode   = OP_PIXEL;
            item.in_blue  = 8'($urandom_range(255));
            item.in_green = 8'($urandom_range(255));
            item.in_red   = 8'($urandom_range(255));
            send_item(item);
        end
    endtask

    // random frame sizes and content, cut frames, back-to-back frames
    task automatic test_random_frames(input int unsigned budget);
        int unsigned             stop_at;
        bit                      need_config;
        bit                      cut;
        logic [CFG_DATA_W-1:0]   w_val;
        logic [CFG_DATA_W-1:0]   h_val;
        logic [CFG_DATA_W-1:0]   s_val;
        stop_at     = items_sent + budget;
        need_config = 1'b1;
        while (items_sent < stop_at)
        begin
            case ($urandom_range(9))
                0:       w_val = 13'($urandom_range(2));
                1, 2:    w_val = 13'($urandom_range(40, 11));
                default: w_val = 13'($urandom_range(10, 3));
            endcase
            case ($urandom_range(9))
                0:       h_val = 13'($urandom_range(2));
                1:       h_val = 13'($urandom_range(10, 7));
                default: h_val = 13'($urandom_range(6, 3));
            endcase
            case ($urandom_range(4))
                0:       s_val = 13'd0;
                1:       s_val = 13'd255;
                default: s_val = 13'($urandom_range(8191));
            endcase

            if (need_config || $urandom_range(2) == 0)
            begin
                wait_for_drain();
                write_reg(REG_WIDTH, w_val);
                write_reg(REG_HEIGHT, h_val);
                write_reg(REG_STEP, s_val);
                if ($urandom_range(3) == 0)
                    write_reg(REG_NONE, 13'($urandom_range(8191)));
            end
            else if ($urandom_range(3) == 0)
            begin
                // step change alone keeps the frame position
                wait_for_drain();
                write_reg(REG_STEP, s_val);
            end
            cut = ($urandom_range(99) < 15);
            send_frame(cut);
            need_config = cut;
        end
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_output_backpressure();
        int i;
        wait_for_drain();
        write_reg(REG_WIDTH, 13'd6);
        write_reg(REG_HEIGHT, 13'd5);
        write_reg(REG_STEP, 13'd9);
        hold_pending = 1'b1;
        for (i = 0; i < 3; i++)
            send_frame(1'b0);
    endtask

    task automatic report_mismatch(input string what, input dst_item_t exp_px,
                                   input dst_item_t got_px);
        failures++;
        if (failures <= REPORT_MAX)
            $display("%0t: %s: expected b=%0d g=%0d r=%0d last=%0b, %s",
                     $time, what, exp_px.out_blue, exp_px.out_green, exp_px.out_red,
                     exp_px.frame_last,
                     $sformatf("got b=%0d g=%0d r=%0d last=%0b",
                               got_px.out_blue, got_px.out_green, got_px.out_red,
                               got_px.frame_last));
    endtask

    // result checker: each transaction against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && dst_valid && !dst_stall)
        begin
            results_seen++;
            if (expected_pixels.size() == 0)
                report_mismatch("result with nothing pending", '0, dst_data);
            else
            begin
                want = expected_pixels.pop_front();
                if (dst_data.out_blue   !== want.out_blue  ||
                    dst_data.out_green  !== want.out_green ||
                    dst_data.out_red    !== want.out_red   ||
                    dst_data.frame_last !== want.frame_last)
                    report_mismatch("pixel mismatch", want, dst_data);
            end
            if (dst_data.frame_last === 1'b1) frames_seen++;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        dst_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                dst_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            dst_stall <= ($urandom_range(99) < dst_stall_pct);
        end
    end

    // watchdog: too long without any transaction on either side
    initial
    begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_MAX)
        begin
            @(posedge clk);
            if ((src_valid === 1'b1 && src_stall === 1'b0) ||
                (dst_valid === 1'b1 && dst_stall === 1'b0))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout: no transaction for %0d cycles, %0d results pending",
                 WATCHDOG_MAX, expected_pixels.size());
        $display("== FAIL ==");
        $finish;
    end

    // test sequence
    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        src_valid = 1'b0;
        src_data  = '0;

        // predicted state after reset
        foreach (upper_row[i])
        begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
        end
        foreach (nbhd[i]) nbhd[i] = '0;
        frame_w      = WIDTH_RST;
        frame_h      = HEIGHT_RST;
        stretch_step = STEP_RST;
        restart_scan();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_frame_size_limits();
        test_random_frames(220);
        src_gap_pct   = 63;
        dst_stall_pct = 25;
        test_random_frames(220);
        src_gap_pct   = 0;
        dst_stall_pct = 0;
        test_random_frames(220);
        test_output_backpressure();
        wait_for_drain();

        $display("Sent %0d transactions, checked %0d results over %0d frames, %0d failures.",
                 items_sent, results_seen, frames_seen, failures);
        $display("Frames from 3x3 to 40x10, clamped and masked sizes, steps 0 to 255,");
        $display("cut frames, three idling mixes and a long output hold.");
        if (failures == 0 && expected_pixels.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/ncs_pkg.sv
rtl/core/ncs_line_store.sv
rtl/core/ncs_scan.sv
rtl/core/ncs_window.sv
rtl/core/ncs_stretch.sv
rtl/core/neighborhood_contrast_stretch.sv
verif/tb_neighborhood_contrast_stretch.sv
